// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// consequence that must hold in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/wsm_pkg.sv =====
package wsm_pkg;

   localparam int MAX_PATTERN_BYTES = 32;
   localparam int PATTERN_BITS      = MAX_PATTERN_BYTES * 8;
   localparam int POS_BITS          = 6;
   localparam int BYTE_SEL_BITS     = $clog2(MAX_PATTERN_BYTES);
   localparam int QUEUE_DEPTH       = 2;
   localparam int QUEUE_PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_BITS    = 3;

   localparam logic [7:0] WILDCARD_BYTE = 8'h2A;

   typedef logic [7:0]          byte_type;
   typedef logic [POS_BITS-1:0] pos_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_WORD_0 = 3'd0,
      CSR_PATTERN_WORD_1 = 3'd1,
      CSR_PATTERN_WORD_2 = 3'd2,
      CSR_PATTERN_WORD_3 = 3'd3,
      CSR_PATTERN_LENGTH = 3'd4
   } csr_index_type;

   // pattern setup handed from the register bank to the matcher
   typedef struct packed {
      logic                    clear;
      logic [PATTERN_BITS-1:0] pattern;
      pos_type                 length;
   } cfg_type;

endpackage

// ===== rtl/wsm_queue.sv =====
module wsm_queue import wsm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  byte_type in_data,
   output logic     out_valid,
   output byte_type out_data,
   input  logic     out_pop
);

`include "assert_macros.svh"

   byte_type                  mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      push, pop;

   assign in_ready  = (count_ff != QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   `ASSERT_ALWAYS(a_queue_count_bound, clock, reset, count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
   `ASSERT_NEXT(a_queue_fill, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

// ===== rtl/wsm_engine.sv =====
module wsm_engine import wsm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     item_valid,
   input  byte_type item_data,
   output logic     item_pop,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output logic     rsp_match
);

`include "assert_macros.svh"

   pos_type  pos_ff, pos_in;
   pos_type  run_ff, run_in;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     rsp_match_ff, rsp_match_in;
   pos_type  len;
   byte_type pat_byte;
   logic     can_emit;
   logic     skip;
   logic     hit;
   pos_type  eval_pos;
   pos_type  eval_run;

   // lengths above the pattern storage are clipped
   assign len = (cfg.length > POS_BITS'(MAX_PATTERN_BYTES)) ?
                POS_BITS'(MAX_PATTERN_BYTES) : cfg.length;
   assign pat_byte = cfg.pattern[pos_ff[BYTE_SEL_BITS-1:0] * 8 +: 8];
   assign can_emit = !rsp_valid_ff || rsp_ready;
   // one wildcard stepped over per cycle, if not stalled, before the compare
   assign skip     = (len != '0) && (pos_ff < len) && (pat_byte == WILDCARD_BYTE);

   always_comb begin
      eval_pos = pos_ff;
      eval_run = run_ff;
      hit      = 1'b0;
      if (pos_ff >= len) begin
         hit = 1'b1;
      end else begin
         if (run_ff == POS_BITS'(1)) begin
            if (item_data == pat_byte) begin
               eval_pos = pos_ff + 1'b1;
               eval_run = run_ff + 1'b1;
            end
         end else if (run_ff > POS_BITS'(1)) begin
            if (item_data != pat_byte) begin
               // back to the last wildcard, which is then stepped over again
               eval_pos = (run_ff > pos_ff) ? '0 : pos_ff - run_ff;
               eval_run = POS_BITS'(1);
            end else begin
               eval_pos = pos_ff + 1'b1;
               eval_run = run_ff + 1'b1;
            end
         end else if (item_data == pat_byte) begin
            eval_pos = pos_ff + 1'b1;
         end else begin
            eval_pos = '0;
         end
         if (eval_pos >= len) begin
            hit = 1'b1;
         end
      end
      if (hit) begin
         eval_pos = '0;
         eval_run = '0;
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      run_in       = run_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_match_in = rsp_match_ff;
      item_pop     = 1'b0;
      if (cfg.clear) begin
         pos_in = '0;
         run_in = '0;
      end else if (item_valid && can_emit) begin
         if (len == '0) begin
            item_pop     = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_match_in = 1'b0;
         end else if (skip) begin
            pos_in = pos_ff + 1'b1;
            run_in = POS_BITS'(1);
         end else begin
            item_pop     = 1'b1;
            pos_in       = eval_pos;
            run_in       = eval_run;
            rsp_valid_in = 1'b1;
            rsp_match_in = hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_match_ff <= rsp_match_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_match = rsp_match_ff;

   `ASSERT_ALWAYS(a_pos_bound, clock, reset, pos_ff <= POS_BITS'(MAX_PATTERN_BYTES))
   `ASSERT_NEXT(a_hit_clears, clock, reset, item_pop && !cfg.clear && rsp_match_in, pos_ff == '0 && run_ff == '0)
   `ASSERT_NEXT(a_skip_holds_item, clock, reset, item_valid && !item_pop, item_valid)

endmodule

// ===== rtl/wildcard_stream_matcher.sv =====
// Byte-stream pattern matcher with '*' wildcards. Each byte taken on req_
// yields one result on rsp_ whose bit 0 is set when that byte completes the
// pattern held in the csr_ registers (indexes 0 to 3: pattern bytes, low byte
// first; index 4: pattern length, zero disables matching). A two-entry input
// queue decouples req_ from the matcher, and the result sits in an output
// register, so a byte can be taken while a result waits. The matcher steps
// over each wildcard at the current pattern position before it compares a
// byte. A csr_ write to indexes 0 to 4 restarts the search; csr_ writes are
// for an idle block.
module wildcard_stream_matcher import wsm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [7:0] data_byte
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,   // [0] match_found, [7:1] zero
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [63:0]               csr_data
);

   logic [PATTERN_BITS-1:0] pattern_ff, pattern_in;
   pos_type                 length_ff, length_in;
   logic                    clear;
   cfg_type                 cfg;
   logic                    item_valid;
   byte_type                item_data;
   logic                    item_pop;
   logic                    rsp_match;

   assign csr_ready = 1'b1;

   always_comb begin
      pattern_in = pattern_ff;
      length_in  = length_ff;
      clear      = 1'b0;
      if (csr_valid) begin
         case (csr_index)
            CSR_PATTERN_WORD_0: begin
               pattern_in[0 +: 64] = csr_data;
               clear = 1'b1;
            end
            CSR_PATTERN_WORD_1: begin
               pattern_in[64 +: 64] = csr_data;
               clear = 1'b1;
            end
            CSR_PATTERN_WORD_2: begin
               pattern_in[128 +: 64] = csr_data;
               clear = 1'b1;
            end
            CSR_PATTERN_WORD_3: begin
               pattern_in[192 +: 64] = csr_data;
               clear = 1'b1;
            end
            CSR_PATTERN_LENGTH: begin
               length_in = csr_data[POS_BITS-1:0];
               clear     = 1'b1;
            end
            default: begin
               clear = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= '0;
      end else begin
         pattern_ff <= pattern_in;
         length_ff  <= length_in;
      end
   end

   assign cfg.clear   = clear;
   assign cfg.pattern = pattern_ff;
   assign cfg.length  = length_ff;

   wsm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (item_valid),
      .out_data  (item_data),
      .out_pop   (item_pop)
   );

   wsm_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_pop   (item_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_match  (rsp_match)
   );

   assign rsp_tdata = {7'b0, rsp_match};

endmodule
